@@ design/spfr_pkg.sv @@
`timescale 1ns / 1ps
package spfr_pkg;

  localparam int unsigned PosW = 9;
  localparam int unsigned MagicLen = 6;
  localparam logic [PosW-1:0] PosVersion = PosW'(6);
  localparam logic [PosW-1:0] PosType = PosW'(7);
  localparam logic [PosW-1:0] PosLength = PosW'(8);
  localparam logic [PosW-1:0] PayloadStart = PosW'(9);

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [2:0] STATUS_RPC_OK = 3'd0;
  localparam logic [2:0] STATUS_OTHER_OK = 3'd1;
  localparam logic [2:0] STATUS_BAD_SUM = 3'd2;
  localparam logic [2:0] STATUS_RPC_SHORT = 3'd3;
  localparam logic [2:0] STATUS_INNER_LEN = 3'd4;

  localparam logic [7:0] VERSION_RESET = 8'd1;
  localparam logic [7:0] RPC_TYPE_RESET = 8'd3;

  // Word index of each configuration register (byte address bit 2)
  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_RPC_TYPE = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] frame_status;
    logic [7:0] frame_type;
    logic [7:0] payload_length;
    logic [7:0] command;
    logic [7:0] inner_length;
  } spfr_result_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'h49;  // I
      3'd1: val = 8'h4D;  // M
      3'd2: val = 8'h50;  // P
      3'd3: val = 8'h52;  // R
      3'd4: val = 8'h4F;  // O
      3'd5: val = 8'h56;  // V
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ design/spfr_parser.sv @@
`timescale 1ns / 1ps
module spfr_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            protocol_version,
  input  logic [7:0]            rpc_frame_type,
  output logic                  emit,
  output spfr_pkg::spfr_result_t result
);
  import spfr_pkg::*;

  logic [PosW-1:0] position, position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] type_held, type_held_next;
  logic [7:0] length_held, length_held_next;
  logic [7:0] command_held, command_held_next;
  logic [7:0] inner_length_held, inner_length_held_next;

  logic [PosW-1:0] frame_end;
  logic [PosW-1:0] payload_offset;
  logic [7:0] sum_plus;
  logic [2:0] status;

  assign frame_end = PayloadStart + {1'b0, length_held};
  assign payload_offset = position - PayloadStart;
  assign sum_plus = running_sum + rx_byte;

  always_comb begin
    priority if (running_sum != rx_byte) begin
      status = STATUS_BAD_SUM;
    end else if (type_held != rpc_frame_type) begin
      status = STATUS_OTHER_OK;
    end else if (length_held < 8'd2) begin
      status = STATUS_RPC_SHORT;
    end else if (inner_length_held != length_held - 8'd2) begin
      status = STATUS_INNER_LEN;
    end else begin
      status = STATUS_RPC_OK;
    end
  end

  always_comb begin
    position_next = position;
    running_sum_next = running_sum;
    type_held_next = type_held;
    length_held_next = length_held;
    command_held_next = command_held;
    inner_length_held_next = inner_length_held;
    emit = 1'b0;
    result = '0;
    priority if (position < PosW'(MagicLen)) begin
      if (rx_byte != magic_byte(position[2:0])) begin
        // drop the byte, no re-check as a first magic byte
        position_next = '0;
      end else begin
        running_sum_next = (position == '0) ? rx_byte : sum_plus;
        position_next = position + 1'b1;
      end
    end else if (position == PosVersion) begin
      if (rx_byte != protocol_version) begin
        position_next = '0;
      end else begin
        running_sum_next = sum_plus;
        position_next = position + 1'b1;
      end
    end else if (position == PosType) begin
      type_held_next = rx_byte;
      running_sum_next = sum_plus;
      position_next = position + 1'b1;
    end else if (position == PosLength) begin
      length_held_next = rx_byte;
      command_held_next = '0;
      inner_length_held_next = '0;
      running_sum_next = sum_plus;
      position_next = position + 1'b1;
    end else if (position < frame_end) begin
      if (payload_offset == '0) begin
        command_held_next = rx_byte;
      end
      if (payload_offset == PosW'(1)) begin
        inner_length_held_next = rx_byte;
      end
      running_sum_next = sum_plus;
      position_next = position + 1'b1;
      emit = 1'b1;
      result.kind = KIND_PAYLOAD;
      result.payload_byte = rx_byte;
      result.payload_index = payload_offset[7:0];
    end else begin
      // checksum byte closes the frame
      position_next = '0;
      emit = 1'b1;
      result.kind = KIND_REPORT;
      result.frame_status = status;
      result.frame_type = type_held;
      result.payload_length = length_held;
      result.command = command_held;
      result.inner_length = inner_length_held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      running_sum <= '0;
      type_held <= '0;
      length_held <= '0;
      command_held <= '0;
      inner_length_held <= '0;
    end else if (advance) begin
      position <= position_next;
      running_sum <= running_sum_next;
      type_held <= type_held_next;
      length_held <= length_held_next;
      command_held <= command_held_next;
      inner_length_held <= inner_length_held_next;
    end
  end

endmodule

@@ design/spfr_out_stage.sv @@
`timescale 1ns / 1ps
module spfr_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  spfr_pkg::spfr_result_t din,
  input  logic                  out_ready,
  output logic                  can_load,
  output logic                  out_valid,
  output spfr_pkg::spfr_result_t dout
);
  import spfr_pkg::*;

  spfr_result_t held;

  assign can_load = !out_valid || out_ready;
  assign dout = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= din;
    end
  end

endmodule

@@ design/serial_provisioning_frame_receiver.sv @@
`timescale 1ns / 1ps
// Serial provisioning frame receiver: takes one received byte per cycle while
// in_ready is high and parses IMPROV-framed requests. Each byte passes an
// input register, is decoded combinationally against the frame position and
// lands in an output register. A byte's result (a payload byte, or the
// end-of-frame report on the checksum byte) shows on the outputs once the
// output register has loaded it, and stays there until out_ready takes it.
// Throughput is one byte per cycle; in_ready drops only while the output
// register holds a result that has not been taken and the input register is
// full. Bytes of the magic word, version, type and length produce no result.
// Registers: protocol_version at 0x0 (reset 1), rpc_frame_type at 0x4
// (reset 3); write them only while no frame byte is in flight.
module serial_provisioning_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [2:0]  frame_status,
  output logic [7:0]  frame_type,
  output logic [7:0]  payload_length,
  output logic [7:0]  command,
  output logic [7:0]  inner_length
);
  import spfr_pkg::*;

  logic [7:0] protocol_version;
  logic [7:0] rpc_frame_type;

  logic       byte_valid;
  logic [7:0] byte_held;
  logic       advance;
  logic       can_load;
  logic       emit;
  spfr_result_t result;
  spfr_result_t out_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= VERSION_RESET;
      rpc_frame_type <= RPC_TYPE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_VERSION: protocol_version <= pwdata[7:0];
        REG_RPC_TYPE: rpc_frame_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VERSION: prdata = {24'd0, protocol_version};
      REG_RPC_TYPE: prdata = {24'd0, rpc_frame_type};
      default: prdata = '0;
    endcase
  end

  // input register: hold the byte until the parser can advance
  assign advance = byte_valid && can_load;
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_held <= rx_byte;
    end
  end

  spfr_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .rx_byte          (byte_held),
    .protocol_version (protocol_version),
    .rpc_frame_type   (rpc_frame_type),
    .emit             (emit),
    .result           (result)
  );

  spfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .din       (result),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .dout      (out_data)
  );

  assign kind = out_data.kind;
  assign payload_byte = out_data.payload_byte;
  assign payload_index = out_data.payload_index;
  assign frame_status = out_data.frame_status;
  assign frame_type = out_data.frame_type;
  assign payload_length = out_data.payload_length;
  assign command = out_data.command;
  assign inner_length = out_data.inner_length;

endmodule

@@ dv/serial_provisioning_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
module serial_provisioning_frame_receiver_tb;
  import spfr_pkg::*;

  localparam string MagicText = "IMPROV";

  class frame_parse_scoreboard;
    logic [7:0] version_reg;
    logic [7:0] rpc_type_reg;
    logic [8:0] pos;
    logic [7:0] sum;
    logic [7:0] type_q;
    logic [7:0] len_q;
    logic [7:0] cmd_q;
    logic [7:0] inner_q;
    spfr_result_t awaited_outputs[$];
    int errors;

    function new();
      version_reg = VERSION_RESET;
      rpc_type_reg = RPC_TYPE_RESET;
      pos = '0;
      sum = '0;
      type_q = '0;
      len_q = '0;
      cmd_q = '0;
      inner_q = '0;
      errors = 0;
    endfunction

    // Advance the parser by one accepted byte and queue what it should emit.
    function void parse_byte(logic [7:0] b);
      spfr_result_t r;
      logic [8:0] payload_end;
      logic [8:0] idx;
      r = '0;
      payload_end = PayloadStart + {1'b0, len_q};
      if (pos < MagicLen) begin
        if (b != MagicText[pos]) begin
          pos = '0;
        end else begin
          sum = (pos == 0) ? b : sum + b;
          pos = pos + 9'd1;
        end
      end else if (pos == PosVersion) begin
        if (b != version_reg) begin
          pos = '0;
        end else begin
          sum = sum + b;
          pos = pos + 9'd1;
        end
      end else if (pos == PosType) begin
        type_q = b;
        sum = sum + b;
        pos = pos + 9'd1;
      end else if (pos == PosLength) begin
        len_q = b;
        cmd_q = '0;
        inner_q = '0;
        sum = sum + b;
        pos = pos + 9'd1;
      end else if (pos < payload_end) begin
        idx = pos - PayloadStart;
        if (idx == 0) begin
          cmd_q = b;
        end else if (idx == 1) begin
          inner_q = b;
        end
        sum = sum + b;
        pos = pos + 9'd1;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = idx[7:0];
        awaited_outputs.insert(awaited_outputs.size(), r);
      end else begin
        // checksum byte closes the frame
        pos = '0;
        if (sum != b) begin
          r.frame_status = STATUS_BAD_SUM;
        end else if (type_q != rpc_type_reg) begin
          r.frame_status = STATUS_OTHER_OK;
        end else if (len_q < 8'd2) begin
          r.frame_status = STATUS_RPC_SHORT;
        end else if (inner_q != (len_q - 8'd2)) begin
          r.frame_status = STATUS_INNER_LEN;
        end else begin
          r.frame_status = STATUS_RPC_OK;
        end
        r.kind = KIND_REPORT;
        r.frame_type = type_q;
        r.payload_length = len_q;
        r.command = cmd_q;
        r.inner_length = inner_q;
        awaited_outputs.insert(awaited_outputs.size(), r);
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_output(spfr_result_t got);
      spfr_result_t want;
      if (awaited_outputs.size() == 0) begin
        $error("unexpected output: kind %0d byte 0x%0h status %0d",
               got.kind, got.payload_byte, got.frame_status);
        errors++;
        return;
      end
      want = awaited_outputs.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("frame_status", want.frame_status, got.frame_status);
      compare_field("frame_type", want.frame_type, got.frame_type);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("command", want.command, got.command);
      compare_field("inner_length", want.inner_length, got.inner_length);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [2:0]  frame_status;
  logic [7:0]  frame_type;
  logic [7:0]  payload_length;
  logic [7:0]  command;
  logic [7:0]  inner_length;

  frame_parse_scoreboard sb;
  bit in_idle_on;
  bit out_idle_on;
  bit long_hold_req;
  int frame_bytes;

  serial_provisioning_frame_receiver u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .payload_byte(payload_byte),
    .payload_index(payload_index),
    .frame_status(frame_status),
    .frame_type(frame_type),
    .payload_length(payload_length),
    .command(command),
    .inner_length(inner_length)
  );

  always #1 clk = ~clk;

  task automatic apb_write(input logic reg_idx, input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {24'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_VERSION) begin
      sb.version_reg = val;
    end else begin
      sb.rpc_type_reg = val;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.parse_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len,
                            input logic [7:0] cmd, input logic [7:0] inner,
                            input bit bad_sum);
    logic [7:0] fb[$];
    logic [7:0] sum;
    for (int i = 0; i < 6; i++) fb.insert(fb.size(), MagicText[i]);
    fb.insert(fb.size(), sb.version_reg);
    fb.insert(fb.size(), ftype);
    fb.insert(fb.size(), len);
    for (int i = 0; i < len; i++) begin
      fb.insert(fb.size(), i == 0 ? cmd : (i == 1 ? inner : 8'($urandom)));
    end
    sum = '0;
    foreach (fb[i]) sum += fb[i];
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    fb.insert(fb.size(), sum);
    in_idle_on = $urandom_range(0, 3) != 0;
    out_idle_on = $urandom_range(0, 3) != 0;
    foreach (fb[i]) send_byte(fb[i]);
    frame_bytes += fb.size();
  endtask

  // Noise, a cut-off magic word, or a frame header with the wrong version.
  task automatic send_junk(input int pick);
    int n;
    case (pick)
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
      end
      1: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_byte(MagicText[i]);
        send_byte(8'($urandom));
      end
      default: begin
        for (int i = 0; i < 6; i++) send_byte(MagicText[i]);
        send_byte(sb.version_reg ^ 8'($urandom_range(1, 255)));
      end
    endcase
  endtask

  task automatic run_random(input int budget);
    int stop;
    int r;
    logic [7:0] len;
    logic [7:0] ftype;
    logic [7:0] inner;
    stop = frame_bytes + budget;
    while (frame_bytes < stop) begin
      if ($urandom_range(0, 4) == 0) begin
        send_junk($urandom_range(0, 2));
      end else begin
        r = $urandom_range(0, 99);
        len = (r < 80) ? 8'($urandom_range(0, 10)) :
              (r < 97) ? 8'($urandom_range(11, 40)) : 8'($urandom_range(200, 255));
        ftype = ($urandom_range(0, 2) != 0) ? sb.rpc_type_reg : 8'($urandom);
        inner = ($urandom_range(0, 3) != 0) ? len - 8'd2 : 8'($urandom);
        send_frame(ftype, len, 8'($urandom), inner, $urandom_range(0, 6) == 0);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_outputs.size() != 0) @(posedge clk);
    // let a header byte still in the pipe settle before touching registers
    repeat (6) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    spfr_result_t got;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      stall = out_idle_on ? $urandom_range(0, 5) : 0;
      if (long_hold_req) begin
        stall = 150;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {kind, payload_byte, payload_index, frame_status, frame_type,
             payload_length, command, inner_length};
      sb.check_output(got);
    end
  end

  initial begin : watchdog
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] versions[4];
    logic [7:0] rpc_types[4];
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    out_ready = 1'b0;
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    long_hold_req = 1'b0;
    frame_bytes = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed frames under reset register values
    send_frame(RPC_TYPE_RESET, 8'd2, 8'h01, 8'd0, 1'b0);
    send_frame(RPC_TYPE_RESET, 8'd5, 8'hFF, 8'd3, 1'b0);
    send_frame(8'd1, 8'd0, 8'h00, 8'h00, 1'b0);
    send_frame(RPC_TYPE_RESET, 8'd3, 8'h02, 8'd1, 1'b1);
    send_frame(RPC_TYPE_RESET, 8'd0, 8'h00, 8'h00, 1'b0);
    send_frame(RPC_TYPE_RESET, 8'd1, 8'h80, 8'h00, 1'b0);
    send_frame(RPC_TYPE_RESET, 8'd4, 8'h03, 8'd7, 1'b0);
    send_junk(2);
    // a mismatching I must not restart the magic word
    send_byte(MagicText[0]);
    send_byte(MagicText[1]);
    send_frame(RPC_TYPE_RESET, 8'd2, 8'h04, 8'd0, 1'b0);
    send_frame(8'hFF, 8'd2, 8'h05, 8'h7F, 1'b0);

    versions = '{8'd0, 8'd255, 8'($urandom), VERSION_RESET};
    rpc_types = '{8'd255, 8'd0, 8'($urandom), RPC_TYPE_RESET};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      apb_write(REG_VERSION, versions[p]);
      apb_write(REG_RPC_TYPE, rpc_types[p]);
      if (p == 0) begin
        long_hold_req = 1'b1;
        send_frame(sb.rpc_type_reg, 8'd60, 8'h10, 8'd58, 1'b0);
      end else if (p == 1) begin
        send_frame(sb.rpc_type_reg, 8'd255, 8'h20, 8'd253, 1'b0);
      end
      run_random(100);
    end
    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_outputs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
